FILE: sv/y2r_pkg.sv
// Package for the YCbCr to RGB565 converter: request and response structs,
// conversion constants and the small arithmetic helpers. No dependencies.
package y2r_pkg;

    // Field widths.
    localparam int LUMA_W  = 8;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 16;
    localparam int CHR_W   = 9;   // chroma after removing the 128 offset
    localparam int PROD_W  = 18;  // chroma times scale factor
    localparam int FRAC_W  = 8;   // scale is over 256
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = 11;  // luma plus or minus the chroma terms

    // Conversion constants.
    localparam logic [CHAN_W-1:0]        CHROMA_OFFSET = 8'd128;
    localparam logic signed [PROD_W-1:0] K_CR_TO_R     = 18'sd359;
    localparam logic signed [PROD_W-1:0] K_CB_TO_G     = 18'sd88;
    localparam logic signed [PROD_W-1:0] K_CR_TO_G     = 18'sd183;
    localparam logic signed [PROD_W-1:0] K_CB_TO_B     = 18'sd454;
    localparam logic signed [PROD_W-1:0] ROUND_ADJ     = 18'sd255;
    localparam logic signed [SUM_W-1:0]  CHAN_MAX      = 11'sd255;

    // One input request.
    typedef struct packed {
        logic [LUMA_W-1:0] luma_first;
        logic [LUMA_W-1:0] luma_second;
        logic [CHAN_W-1:0] chroma_blue;
        logic [CHAN_W-1:0] chroma_red;
        logic              frame_end_in;
    } t_ycc_req;

    // One output response.
    typedef struct packed {
        logic [PIX_W-1:0] first_pixel;
        logic [PIX_W-1:0] second_pixel;
        logic             second_valid;
        logic             frame_end_out;
    } t_rgb_rsp;

    // Signed divide by 256 that truncates toward zero: negative values are
    // biased by 255 before the arithmetic shift.
    function automatic logic signed [TERM_W-1:0] div_scale(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] adj;
        adj = prod[PROD_W-1] ? (prod + ROUND_ADJ) : prod;
        return adj[PROD_W-1:FRAC_W];
    endfunction

    // Clamp a signed channel sum to 0..255.
    function automatic logic [CHAN_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] v);
        logic [CHAN_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (v > CHAN_MAX) begin
            res = CHAN_MAX[CHAN_W-1:0];
        end else begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/ycbcr_to_rgb565_converter_core.sv
// Top level of the YCbCr to RGB565 converter: four-stage pipeline with
// valid bits per stage. Depends on y2r_pkg and y2r_pack.
//
//  Channel   Signals                          Direction  Payload
//  input     i_valid / o_ready / i_req        in         t_ycc_req
//  output    o_valid / i_ready / o_rsp        out        t_rgb_rsp
//  config    i_cfg_we / i_cfg_wdata           in         pair_mode, 1 bit
//
// One request enters per clock while o_ready is high; its response leaves from the stage 4 register.
// Stages: chroma offset, constant multiplies, truncating divide, sum/clamp/pack.
// Each stage holds while the one after it is full and stalled, so a stall
// on the output drops and repeats nothing. Synchronous active-low reset
// empties the pipeline and clears pair_mode.
module ycbcr_to_rgb565_converter_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  y2r_pkg::t_ycc_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output y2r_pkg::t_rgb_rsp o_rsp
);
    import y2r_pkg::*;

    logic r_pair_mode;

    // Stage 1: chroma with offset removed.
    logic                     r_s1_v;
    logic [LUMA_W-1:0]        r_s1_y0, r_s1_y1;
    logic signed [CHR_W-1:0]  r_s1_cb, r_s1_cr;
    logic                     r_s1_fe, r_s1_pm;
    // Stage 2: scaled chroma products.
    logic                     r_s2_v;
    logic [LUMA_W-1:0]        r_s2_y0, r_s2_y1;
    logic signed [PROD_W-1:0] r_s2_p_r, r_s2_p_gb, r_s2_p_gr, r_s2_p_b;
    logic                     r_s2_fe, r_s2_pm;
    // Stage 3: chroma terms after the divide.
    logic                     r_s3_v;
    logic [LUMA_W-1:0]        r_s3_y0, r_s3_y1;
    logic signed [TERM_W-1:0] r_s3_t_r, r_s3_t_gb, r_s3_t_gr, r_s3_t_b;
    logic                     r_s3_fe, r_s3_pm;
    // Stage 4: output register.
    logic                     r_out_v;
    t_rgb_rsp                 r_out;
    t_rgb_rsp                 n_out;

    logic en1, en2, en3, en4;
    logic [PIX_W-1:0] pix0, pix1;
    logic signed [CHR_W-1:0]  n_s1_cb, n_s1_cr;
    logic signed [PROD_W-1:0] cb_ext, cr_ext;

    // A stage may load when it is empty or the stage after it moves.
    always_comb begin
        en4 = !r_out_v || i_ready;
        en3 = !r_s3_v || en4;
        en2 = !r_s2_v || en3;
        en1 = !r_s1_v || en2;
    end

    assign o_ready = en1;
    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_pair_mode <= i_cfg_wdata;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (en1) r_s1_v  <= i_valid;
            if (en2) r_s2_v  <= r_s1_v;
            if (en3) r_s3_v  <= r_s2_v;
            if (en4) r_out_v <= r_s3_v;
        end
    end

    // Stage 1 offset removal.
    always_comb begin
        n_s1_cb = $signed({1'b0, i_req.chroma_blue}) - $signed({1'b0, CHROMA_OFFSET});
        n_s1_cr = $signed({1'b0, i_req.chroma_red})  - $signed({1'b0, CHROMA_OFFSET});
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_s1_y0 <= i_req.luma_first;
            r_s1_y1 <= i_req.luma_second;
            r_s1_cb <= n_s1_cb;
            r_s1_cr <= n_s1_cr;
            r_s1_fe <= i_req.frame_end_in;
            r_s1_pm <= r_pair_mode;
        end
    end

    // Stage 2 constant multiplies.
    always_comb begin
        cb_ext = PROD_W'(r_s1_cb);
        cr_ext = PROD_W'(r_s1_cr);
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_v) begin
            r_s2_y0   <= r_s1_y0;
            r_s2_y1   <= r_s1_y1;
            r_s2_p_r  <= cr_ext * K_CR_TO_R;
            r_s2_p_gb <= cb_ext * K_CB_TO_G;
            r_s2_p_gr <= cr_ext * K_CR_TO_G;
            r_s2_p_b  <= cb_ext * K_CB_TO_B;
            r_s2_fe   <= r_s1_fe;
            r_s2_pm   <= r_s1_pm;
        end
    end

    // Stage 3 divide by 256 toward zero, each term on its own.
    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_v) begin
            r_s3_y0   <= r_s2_y0;
            r_s3_y1   <= r_s2_y1;
            r_s3_t_r  <= div_scale(r_s2_p_r);
            r_s3_t_gb <= div_scale(r_s2_p_gb);
            r_s3_t_gr <= div_scale(r_s2_p_gr);
            r_s3_t_b  <= div_scale(r_s2_p_b);
            r_s3_fe   <= r_s2_fe;
            r_s3_pm   <= r_s2_pm;
        end
    end

    // Stage 4 sums, clamps and packs both pixels.
    y2r_pack u_pack_first (
        .i_luma      (r_s3_y0),
        .i_r_term    (r_s3_t_r),
        .i_g_term_cb (r_s3_t_gb),
        .i_g_term_cr (r_s3_t_gr),
        .i_b_term    (r_s3_t_b),
        .o_pixel     (pix0)
    );

    y2r_pack u_pack_second (
        .i_luma      (r_s3_y1),
        .i_r_term    (r_s3_t_r),
        .i_g_term_cb (r_s3_t_gb),
        .i_g_term_cr (r_s3_t_gr),
        .i_b_term    (r_s3_t_b),
        .o_pixel     (pix1)
    );

    always_comb begin
        n_out.first_pixel   = pix0;
        n_out.second_pixel  = r_s3_pm ? pix1 : '0;
        n_out.second_valid  = r_s3_pm;
        n_out.frame_end_out = r_s3_fe;
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_s3_v) begin
            r_out <= n_out;
        end
    end

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A single-pixel response carries a zero second pixel.
    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.second_valid |-> o_rsp.second_pixel == '0)
        else $error("second pixel not zero in single mode");

    // Input is refused only when every stage is full.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_s1_v && r_s2_v && r_s3_v && r_out_v && !i_ready)
        else $error("input stalled with a bubble in the pipeline");

    // A stage that moved forward leaves its data in the next stage.
    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v && en4 |=> o_valid)
        else $error("stage three request lost");

endmodule

FILE: sv/y2r_pack.sv
// One pixel's final step: adds or subtracts the chroma terms from luma, clamps
// each channel and packs 5-6-5. Depends on y2r_pkg.
module y2r_pack (
    input  logic [y2r_pkg::LUMA_W-1:0]        i_luma,
    input  logic signed [y2r_pkg::TERM_W-1:0] i_r_term,
    input  logic signed [y2r_pkg::TERM_W-1:0] i_g_term_cb,
    input  logic signed [y2r_pkg::TERM_W-1:0] i_g_term_cr,
    input  logic signed [y2r_pkg::TERM_W-1:0] i_b_term,
    output logic [y2r_pkg::PIX_W-1:0]         o_pixel
);
    import y2r_pkg::*;

    logic signed [SUM_W-1:0] luma_s;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;
    logic [CHAN_W-1:0]       chan_r;
    logic [CHAN_W-1:0]       chan_g;
    logic [CHAN_W-1:0]       chan_b;

    // Channel sums; the two green terms were truncated separately upstream.
    always_comb begin
        luma_s = $signed({{(SUM_W-LUMA_W){1'b0}}, i_luma});
        sum_r  = luma_s + SUM_W'(i_r_term);
        sum_g  = luma_s - SUM_W'(i_g_term_cb) - SUM_W'(i_g_term_cr);
        sum_b  = luma_s + SUM_W'(i_b_term);
    end

    // Clamp and keep the top bits of each channel.
    always_comb begin
        chan_r  = clamp_chan(sum_r);
        chan_g  = clamp_chan(sum_g);
        chan_b  = clamp_chan(sum_b);
        o_pixel = {chan_r[7:3], chan_g[7:2], chan_b[7:3]};
    end

endmodule
